/* src/brr_pkg.sv */
// Package for the BRR ADPCM decoder: shared types, constants and the
// nibble predictor and de-emphasis arithmetic. No dependencies.
package brr_pkg;

  // Nibble sequencer phases
  typedef enum logic [1:0] {
    PH_HI,
    PH_LO,
    PH_FLUSH
  } brr_phase_e;

  // Item passed from the sequencer to the de-emphasis stage
  typedef struct packed {
    logic               flush;   // end-of-stream flush slot, no sample
    logic               clr;     // clear filter state first (stream start)
    logic               fin;     // last sample of the end block
    logic signed [15:0] sample;
  } brr_item_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } brr_result_t;

  // Headers at or above this code carry an invalid shift
  localparam logic [7:0] HdrBadShift = 8'hD0;

  localparam logic signed [19:0] SampleMax = 20'sd32767;
  localparam logic signed [19:0] SampleMin = -20'sd32768;
  localparam logic signed [19:0] BadShiftNeg = -20'sd2048;

  // De-emphasis taps, oldest first
  localparam logic signed [27:0] EmphCoefOld = 28'sd370;
  localparam logic signed [27:0] EmphCoefMid = 28'sd1305;
  localparam logic signed [27:0] EmphCoefNew = 28'sd374;

  // Predictor filter codes
  localparam logic [1:0] FiltNone = 2'd0;
  localparam logic [1:0] FiltOne  = 2'd1;
  localparam logic [1:0] FiltTwo  = 2'd2;
  localparam logic [1:0] FiltThree = 2'd3;

  // Decode one nibble against the header and two history values.
  // Returns the new 15-bit history value; the output sample is twice it.
  function automatic logic signed [14:0] brr_decode(
    input logic [3:0]         nib,
    input logic [7:0]         hdr,
    input logic signed [14:0] l1,
    input logic signed [14:0] l2
  );
    logic signed [19:0] n20;
    logic signed [19:0] x1;
    logic signed [19:0] x2;
    logic signed [19:0] sc;
    logic signed [19:0] pr;
    logic signed [19:0] acc;
    logic signed [15:0] clamped;
    n20 = {{16{nib[3]}}, nib};
    x1  = {{5{l1[14]}}, l1};
    x2  = {{5{l2[14]}}, l2};
    // scale by the header shift
    if (hdr >= HdrBadShift) begin
      sc = nib[3] ? BadShiftNeg : '0;
    end else begin
      sc = (n20 <<< hdr[7:4]) >>> 1;
    end
    // predictor
    case (hdr[3:2])
      FiltOne:   pr = x1 + ((-x1) >>> 4);
      FiltTwo:   pr = (x1 <<< 1) + ((-(x1 * 20'sd3)) >>> 5) - x2 + (x2 >>> 4);
      FiltThree: pr = (x1 <<< 1) + ((-(x1 * 20'sd13)) >>> 6) - x2
                      + ((x2 * 20'sd3) >>> 4);
      default:   pr = '0;
    endcase
    acc = sc + pr;
    // clamp to 16 bits, then wrap to 15
    if (acc > SampleMax) begin
      clamped = 16'sh7FFF;
    end else if (acc < SampleMin) begin
      clamped = 16'sh8000;
    end else begin
      clamped = acc[15:0];
    end
    return clamped[14:0];
  endfunction

  // Three-tap de-emphasis, sum >> 11 wrapped to 16 bits
  function automatic logic signed [15:0] brr_emph_mix(
    input logic signed [15:0] a,
    input logic signed [15:0] b,
    input logic signed [15:0] c
  );
    logic signed [27:0] sum;
    logic signed [27:0] shifted;
    sum = 28'(a) * EmphCoefOld + 28'(b) * EmphCoefMid + 28'(c) * EmphCoefNew;
    shifted = sum >>> 11;
    return shifted[15:0];
  endfunction

endpackage

/* src/brr_if.sv */
// Handshake interfaces of the BRR decoder: byte input, sample output and
// configuration write channel. No dependencies.
interface brr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;
  modport source (output valid, data_byte, stream_start, input ready);
  modport sink   (input valid, data_byte, stream_start, output ready);
endinterface

interface brr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface brr_cfg_if;
  logic valid;
  logic ready;
  logic deemphasis_on;
  modport source (output valid, deemphasis_on, input ready);
  modport sink   (input valid, deemphasis_on, output ready);
endinterface

/* src/brr_seq.sv */
// Byte sequencer and nibble decoder: block parsing, history and one nibble
// decode per cycle into a staging register that can take it. Uses brr_pkg, brr_if.
module brr_seq
  import brr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  brr_in_if.sink     in_i,
  output logic       item_valid_o,
  output brr_item_t  item_o,
  input  logic       item_take_i
);

  logic [3:0]         pos_q, pos_d;
  logic [7:0]         hdr_q, hdr_d;
  logic signed [14:0] hist1_q, hist1_d;
  logic signed [14:0] hist2_q, hist2_d;
  logic               halted_q, halted_d;
  logic               busy_q, busy_d;
  brr_phase_e         phase_q, phase_d;
  logic [7:0]         byte_q, byte_d;
  logic               end_q, end_d;
  logic               clr_pend_q, clr_pend_d;
  logic               p_valid_q, p_valid_d;
  brr_item_t          p_item_q, p_item_d;

  logic               adv;
  logic               last_phase;
  logic               accept;
  logic               eff_halted;
  logic [3:0]         eff_pos;
  logic               is_hdr;
  logic [3:0]         nib;
  logic signed [14:0] dec;

  // Stage advance and input handshake
  assign adv        = busy_q && (!p_valid_q || item_take_i);
  assign last_phase = (phase_q == PH_FLUSH) || (phase_q == PH_LO && !end_q);
  assign in_i.ready = !busy_q || (adv && last_phase);
  assign accept     = in_i.valid && in_i.ready;

  assign eff_halted = halted_q && !in_i.stream_start;
  assign eff_pos    = in_i.stream_start ? 4'd0 : pos_q;
  assign is_hdr     = (eff_pos == 4'd0) || (eff_pos > 4'd8);

  // Nibble decode, high nibble first
  assign nib = (phase_q == PH_HI) ? byte_q[7:4] : byte_q[3:0];
  assign dec = brr_decode(nib, hdr_q, hist1_q, hist2_q);

  // Next state
  always_comb begin
    pos_d      = pos_q;
    hdr_d      = hdr_q;
    hist1_d    = hist1_q;
    hist2_d    = hist2_q;
    halted_d   = halted_q;
    busy_d     = busy_q;
    phase_d    = phase_q;
    byte_d     = byte_q;
    end_d      = end_q;
    clr_pend_d = clr_pend_q;
    p_valid_d  = p_valid_q;
    p_item_d   = p_item_q;

    // drain staging register
    if (item_take_i) begin
      p_valid_d = 1'b0;
    end

    // nibble step
    if (adv) begin
      p_valid_d       = 1'b1;
      p_item_d.flush  = (phase_q == PH_FLUSH);
      p_item_d.clr    = clr_pend_q;
      p_item_d.fin    = (phase_q == PH_LO) && end_q;
      p_item_d.sample = {dec, 1'b0};
      clr_pend_d      = 1'b0;
      if (phase_q != PH_FLUSH) begin
        hist2_d = hist1_q;
        hist1_d = dec;
      end
      if (last_phase) begin
        busy_d = 1'b0;
      end else if (phase_q == PH_HI) begin
        phase_d = PH_LO;
      end else begin
        phase_d = PH_FLUSH;
      end
    end

    // accepted byte
    if (accept) begin
      if (in_i.stream_start) begin
        hist1_d    = '0;
        hist2_d    = '0;
        halted_d   = 1'b0;
        pos_d      = '0;
        clr_pend_d = 1'b1;
      end
      if (!eff_halted) begin
        if (is_hdr) begin
          hdr_d = in_i.data_byte;
          pos_d = 4'd1;
        end else begin
          busy_d  = 1'b1;
          phase_d = PH_HI;
          byte_d  = in_i.data_byte;
          end_d   = (eff_pos == 4'd8) && hdr_q[0];
          if (eff_pos == 4'd8) begin
            pos_d = '0;
            if (hdr_q[0]) begin
              halted_d = 1'b1;
            end
          end else begin
            pos_d = eff_pos + 4'd1;
          end
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_q      <= '0;
      hist1_q    <= '0;
      hist2_q    <= '0;
      halted_q   <= 1'b0;
      busy_q     <= 1'b0;
      phase_q    <= PH_HI;
      end_q      <= 1'b0;
      clr_pend_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      hdr_q      <= hdr_d;
      hist1_q    <= hist1_d;
      hist2_q    <= hist2_d;
      halted_q   <= halted_d;
      busy_q     <= busy_d;
      phase_q    <= phase_d;
      end_q      <= end_d;
      clr_pend_q <= clr_pend_d;
      p_valid_q  <= p_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    p_item_q <= p_item_d;
  end

  assign item_valid_o = p_valid_q;
  assign item_o       = p_item_q;

endmodule

/* src/brr_emph.sv */
// De-emphasis stage: holds two past samples, filters or passes samples
// through and emits the end-of-stream flush sample. Uses brr_pkg.
module brr_emph
  import brr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        deemph_i,
  input  logic        item_valid_i,
  input  brr_item_t   item_i,
  output logic        item_take_o,
  input  logic        full_i,
  output logic        push_o,
  output brr_result_t push_data_o
);

  logic signed [15:0] older_q, older_d;
  logic signed [15:0] newer_q, newer_d;
  logic               primed_q, primed_d;

  logic signed [15:0] old_eff;
  logic signed [15:0] new_eff;
  logic               primed_eff;
  logic signed [15:0] tap_new;
  logic signed [15:0] mixed;

  assign item_take_o = item_valid_i && !full_i;

  // Stream start drops any held samples
  assign old_eff    = item_i.clr ? '0 : older_q;
  assign new_eff    = item_i.clr ? '0 : newer_q;
  assign primed_eff = item_i.clr ? 1'b0 : primed_q;

  assign tap_new = item_i.flush ? '0 : item_i.sample;
  assign mixed   = brr_emph_mix(old_eff, new_eff, tap_new);

  always_comb begin
    older_d     = older_q;
    newer_d     = newer_q;
    primed_d    = primed_q;
    push_o      = 1'b0;
    push_data_o = '{sample: mixed, last: 1'b0};
    if (item_take_o) begin
      older_d  = old_eff;
      newer_d  = new_eff;
      primed_d = primed_eff;
      if (item_i.flush) begin
        // flush held sample against a zero
        if (deemph_i) begin
          push_o      = 1'b1;
          push_data_o = '{sample: mixed, last: 1'b1};
          older_d     = '0;
          newer_d     = '0;
          primed_d    = 1'b0;
        end
      end else if (!deemph_i) begin
        // pass-through, filter state cleared
        push_o      = 1'b1;
        push_data_o = '{sample: item_i.sample, last: item_i.fin};
        older_d     = '0;
        newer_d     = '0;
        primed_d    = 1'b0;
      end else begin
        push_o   = primed_eff;
        older_d  = new_eff;
        newer_d  = item_i.sample;
        primed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= '0;
      newer_q  <= '0;
      primed_q <= 1'b0;
    end else begin
      older_q  <= older_d;
      newer_q  <= newer_d;
      primed_q <= primed_d;
    end
  end

endmodule

/* src/brr_fifo.sv */
// Two-entry result queue that drives the sample output channel.
// Uses brr_pkg, brr_if.
module brr_fifo
  import brr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  brr_result_t data_i,
  output logic        full_o,
  brr_out_if.source   out_o
);

  brr_result_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        pop;
  brr_result_t head;

  assign full_o    = (count_q == 2'd2);
  assign pop       = out_o.valid && out_o.ready;
  assign head      = mem_q[rd_ptr_q];
  assign out_o.valid  = (count_q != 2'd0);
  assign out_o.sample = head.sample;
  assign out_o.last   = head.last;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/brr_adpcm_decoder.sv */
// BRR ADPCM decoder top level: configuration register and the sequencer,
// de-emphasis and result queue stages. Uses brr_pkg and brr_if.
//
// Decodes a BRR stream one byte per transaction. A header byte gives no
// sample. A data byte holds the input for its high and low nibble slots,
// since the single predictor decodes one nibble per cycle while the staging
// register can take it (the new history value of the high nibble feeds the
// low one); a byte that ends the end block also holds it for the de-emphasis
// flush slot. The next byte is accepted as the last slot of the current byte
// advances. After its nibble is decoded, a sample passes the staging
// register, then the two-entry result queue, with the de-emphasis stage
// combinational between them.
// With de-emphasis on, output runs one sample behind until the end block
// flushes. The configuration channel is always ready and must be written
// only while the decoder is idle.
module brr_adpcm_decoder
  import brr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  brr_cfg_if.sink    cfg_i,
  brr_in_if.sink     in_i,
  brr_out_if.source  out_o
);

  logic        deemph_q, deemph_d;
  logic        item_valid;
  brr_item_t   item;
  logic        item_take;
  logic        full;
  logic        push;
  brr_result_t push_data;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  assign deemph_d    = (cfg_i.valid && cfg_i.ready) ? cfg_i.deemphasis_on : deemph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deemph_q <= 1'b0;
    end else begin
      deemph_q <= deemph_d;
    end
  end

  brr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  brr_emph u_emph (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .deemph_i     (deemph_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .full_i       (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  brr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .out_o  (out_o)
  );

endmodule

/* sim/brr_adpcm_decoder_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for brr_adpcm_decoder: directed and random BRR streams
// against an in-bench decoder model. Depends on brr_pkg and brr_if from src.

module brr_adpcm_decoder_tb
  import brr_pkg::*;
();

  localparam int CycleLimit = 300000;
  localparam int SettleCycles = 20;

  logic clk;
  logic rst_n;

  brr_cfg_if cfg_if ();
  brr_in_if  in_if ();
  brr_out_if out_if ();

  brr_adpcm_decoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder model state
  logic               deemph_en;
  logic [3:0]         blk_pos;
  logic [7:0]         cur_hdr;
  logic signed [14:0] hist_new;
  logic signed [14:0] hist_old;
  logic               stream_halted;
  logic signed [15:0] emph_a;
  logic signed [15:0] emph_b;
  logic               emph_pending;

  brr_result_t pcm_expected[$];

  int err_count = 0;
  int cycle_cnt = 0;
  int in_gap_max = 0;
  int out_stall_max = 0;
  int bytes_decoded = 0;

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("brr_adpcm_decoder_tb: errors");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic void model_reset();
    deemph_en     = 1'b0;
    blk_pos       = '0;
    cur_hdr       = '0;
    hist_new      = '0;
    hist_old      = '0;
    stream_halted = 1'b0;
    emph_a        = '0;
    emph_b        = '0;
    emph_pending  = 1'b0;
  endfunction

  // Scale + predict one nibble, update history; returns the doubled sample
  function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib);
    int n;
    int v;
    int l1;
    int l2;
    n  = nib[3] ? int'(nib) - 16 : int'(nib);
    l1 = hist_new;
    l2 = hist_old;
    if (cur_hdr >= HdrBadShift) begin
      v = (n < 0) ? -2048 : 0;
    end else begin
      v = (n <<< cur_hdr[7:4]) >>> 1;
    end
    case (cur_hdr[3:2])
      FiltOne:   v += l1 + ((-l1) >>> 4);
      FiltTwo:   v += 2 * l1 + ((-3 * l1) >>> 5) - l2 + (l2 >>> 4);
      FiltThree: v += 2 * l1 + ((-13 * l1) >>> 6) - l2 + ((3 * l2) >>> 4);
      default: ;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    hist_old = hist_new;
    hist_new = v[14:0];
    return {hist_new, 1'b0};
  endfunction

  // De-emphasis taps, sum >> 11 wrapped to 16 bits
  function automatic logic signed [15:0] emph_mix(input logic signed [15:0] a,
                                                  input logic signed [15:0] b,
                                                  input logic signed [15:0] c);
    int acc;
    acc = 370 * a + 1305 * b + 374 * c;
    acc = acc >>> 11;
    return acc[15:0];
  endfunction

  function automatic void expect_sample(input logic signed [15:0] s, input logic fin);
    brr_result_t r;
    r.sample = s;
    r.last   = fin;
    pcm_expected.push_back(r);
  endfunction

  function automatic void emph_clear();
    emph_a       = '0;
    emph_b       = '0;
    emph_pending = 1'b0;
  endfunction

  // Route one decoded sample through the optional de-emphasis filter
  function automatic void push_sample(input logic signed [15:0] s, input logic fin);
    if (!deemph_en) begin
      emph_clear();
      expect_sample(s, fin);
      return;
    end
    if (emph_pending) expect_sample(emph_mix(emph_a, emph_b, s), 1'b0);
    emph_a       = emph_b;
    emph_b       = s;
    emph_pending = 1'b1;
    // end block: flush the held sample against a zero
    if (fin) begin
      expect_sample(emph_mix(emph_a, emph_b, '0), 1'b1);
      emph_clear();
    end
  endfunction

  // One accepted byte; returns 0 when the byte is ignored (halted stream)
  function automatic bit predict_byte(input logic [7:0] b, input logic st);
    logic end_blk;
    if (st) begin
      hist_new      = '0;
      hist_old      = '0;
      stream_halted = 1'b0;
      blk_pos       = '0;
      emph_clear();
    end
    if (stream_halted) return 1'b0;
    if (blk_pos == 4'd0 || blk_pos > 4'd8) begin
      cur_hdr = b;
      blk_pos = 4'd1;
      return 1'b1;
    end
    end_blk = (blk_pos == 4'd8) && cur_hdr[0];
    push_sample(decode_nibble(b[7:4]), 1'b0);
    push_sample(decode_nibble(b[3:0]), end_blk);
    if (blk_pos == 4'd8) begin
      blk_pos = '0;
      if (cur_hdr[0]) stream_halted = 1'b1;
    end else begin
      blk_pos = blk_pos + 4'd1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample sink: random stalls, checks each transaction against the model
  // ---------------------------------------------------------------------------
  task automatic check_sample();
    brr_result_t want;
    if (pcm_expected.size() == 0) begin
      flag_error($sformatf("unexpected sample %0d last %0b", out_if.sample, out_if.last));
      return;
    end
    want = pcm_expected.pop_front();
    if (out_if.sample !== want.sample)
      flag_error($sformatf("sample got %0d want %0d", out_if.sample, want.sample));
    if (out_if.last !== want.last)
      flag_error($sformatf("last got %0b want %0b (sample %0d)", out_if.last, want.last,
                           want.sample));
  endtask

  initial begin
    int hold;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = $urandom_range(0, out_stall_max);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      check_sample();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Send one byte; valid stays high when the next byte follows without a gap
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= b;
    in_if.stream_start <= st;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (predict_byte(b, st)) bytes_decoded++;
  endtask

  // Stop sending and wait until every expected sample has arrived
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pcm_expected.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_deemph(input logic on);
    cfg_if.valid         <= 1'b1;
    cfg_if.deemphasis_on <= on;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    deemph_en = on;
  endtask

  // Mostly valid shifts, sometimes the invalid range
  function automatic logic [7:0] random_header();
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) != 0) h[7:4] = 4'($urandom_range(0, 12));
    return h;
  endfunction

  task automatic send_stream(input int n_blocks, input bit with_end, input int tail_len);
    logic [7:0] h;
    for (int k = 0; k < n_blocks; k++) begin
      h    = random_header();
      h[0] = with_end && (k == n_blocks - 1);
      send_byte(h, k == 0);
      for (int j = 0; j < 8; j++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    // tail: a partial block left dangling, or bytes a halted stream must ignore
    for (int j = 0; j < tail_len; j++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Filter off: no start after reset, extreme nibbles at max shift, halt,
  // invalid shift, restart mid-block
  task automatic test_directed_plain();
    logic [7:0] clamp_data[8] = '{8'h7F, 8'h80, 8'hF7, 8'h08, 8'hFF, 8'h00, 8'h77, 8'h88};
    in_gap_max    = 3;
    out_stall_max = 3;
    send_byte(8'hCD, 1'b0);
    foreach (clamp_data[i]) send_byte(clamp_data[i], 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hD6, 1'b1);
    send_byte(8'h8F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h18, 1'b1);
    send_byte(8'h9C, 1'b0);
    send_byte(8'h3E, 1'b0);
    drain();
  endtask

  // Filter on: full end block with alternating extremes and its flush
  task automatic test_directed_emphasis();
    logic [7:0] swing_data[8] = '{8'h7F, 8'h80, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'h88, 8'h77};
    write_deemph(1'b1);
    send_byte(8'hC5, 1'b1);
    foreach (swing_data[i]) send_byte(swing_data[i], 1'b0);
    drain();
  endtask

  task automatic test_random_streams(input logic on, input int gap_lim, input int stall_lim,
                                     input int n_bytes);
    int goal;
    int pick;
    int half;
    write_deemph(on);
    out_stall_max = stall_lim;
    goal = bytes_decoded + n_bytes;
    half = bytes_decoded + n_bytes / 2;
    while (bytes_decoded < goal) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : gap_lim;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_stream($urandom_range(1, 3), 1'b1, $urandom_range(0, 2));
      end else if (pick < 8) begin
        send_stream($urandom_range(1, 2), 1'b0, $urandom_range(0, 7));
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      // hold the sender once until the sink has caught up
      if (half > 0 && bytes_decoded >= half) begin
        half = 0;
        drain();
      end
    end
    drain();
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.data_byte       = '0;
    in_if.stream_start    = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.deemphasis_on  = 1'b0;
    model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_plain();
    test_directed_emphasis();
    test_random_streams(1'b0, 14, 14, 100);
    test_random_streams(1'b1, 14, 14, 100);
    test_random_streams(1'b1, 0, 0, 100);
    test_random_streams(1'b0, 0, 14, 90);

    drain();
    if (err_count == 0) begin
      $display("brr_adpcm_decoder_tb: clean");
    end else begin
      $display("brr_adpcm_decoder_tb: errors");
    end
    $finish;
  end

endmodule
